@@ sv/nbi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbi_pkg: shared types, constants and microcode for the 8-channel notch and
// bandpass filter.
// Holds the word types, the coefficient table and the sequencer program.
// ----------------------------------------------------------------------------
package nbi_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int MAX_CH       = 8;
  localparam int SAMPLE_W     = 16;
  localparam int HIST_W       = 24;
  localparam int COEF_W       = 24;
  localparam int OPND_W       = HIST_W + 1;
  localparam int PROD_W       = OPND_W + COEF_W;
  localparam int ACC_W        = PROD_W + 3;
  localparam int PC_W         = 5;
  localparam int LAST_STEP    = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic signed [SAMPLE_W-1:0] sample_ch2;
    logic signed [SAMPLE_W-1:0] sample_ch3;
    logic signed [SAMPLE_W-1:0] sample_ch4;
    logic signed [SAMPLE_W-1:0] sample_ch5;
    logic signed [SAMPLE_W-1:0] sample_ch6;
    logic signed [SAMPLE_W-1:0] sample_ch7;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_ch0;
    logic signed [SAMPLE_W-1:0] filtered_ch1;
    logic signed [SAMPLE_W-1:0] filtered_ch2;
    logic signed [SAMPLE_W-1:0] filtered_ch3;
    logic signed [SAMPLE_W-1:0] filtered_ch4;
    logic signed [SAMPLE_W-1:0] filtered_ch5;
    logic signed [SAMPLE_W-1:0] filtered_ch6;
    logic signed [SAMPLE_W-1:0] filtered_ch7;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_ZERO, OP_X, OP_NX0, OP_NX1, OP_NY0, OP_NY1, OP_VBX3, OP_BX1,
    OP_BY0, OP_BY1, OP_BY2, OP_BY3
  } opnd_sel_t;

  // Feedback coefficients are stored already negated.
  typedef enum logic [3:0] {
    CF_NB0, CF_NA1, CF_NNA1, CF_NNA2, CF_BB0, CF_BB2,
    CF_NBA1, CF_NBA2, CF_NBA3, CF_NBA4
  } coef_sel_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {ACT_NONE, ACT_NOTCH, ACT_BAND, ACT_EMIT} act_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_CHAN, JMP_OUT} jmp_t;

  typedef struct packed {
    opnd_sel_t       opnd;
    coef_sel_t       coef;
    logic            mul_en;
    acc_op_t         acc;
    act_t            act;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } seq_stat_t;

  localparam ucode_t UC_NOP = '{opnd: OP_ZERO, coef: CF_NB0, mul_en: 1'b0,
                                acc: ACC_NONE, act: ACT_NONE, jmp: JMP_NEXT,
                                target: '0};

  function automatic logic signed [COEF_W-1:0] coef_value(input coef_sel_t c);
    logic signed [COEF_W-1:0] v;
    case (c)
      CF_NB0:  v = 24'sd1021313;
      CF_NA1:  v = -24'sd1942697;
      CF_NNA1: v = 24'sd1942697;
      CF_NNA2: v = -24'sd994155;
      CF_BB0:  v = 24'sd109157;
      CF_BB2:  v = -24'sd218314;
      CF_NBA1: v = 24'sd2855377;
      CF_NBA2: v = -24'sd2997774;
      CF_NBA3: v = 24'sd1517331;
      CF_NBA4: v = -24'sd335230;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic ucode_t mk(input opnd_sel_t o, input coef_sel_t c,
                                input logic m, input acc_op_t a,
                                input act_t t, input jmp_t j);
    ucode_t w;
    w.opnd   = o;
    w.coef   = c;
    w.mul_en = m;
    w.acc    = a;
    w.act    = t;
    w.jmp    = j;
    w.target = '0;
    return w;
  endfunction

  // One channel takes steps 0 to 15. Each accumulate step adds the product
  // formed in the step before it.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = mk(OP_X,    CF_NB0,  1'b1, ACC_NONE, ACT_NONE,  JMP_NEXT);
      5'd1:    w = mk(OP_NX0,  CF_NA1,  1'b1, ACC_LOAD, ACT_NONE,  JMP_NEXT);
      5'd2:    w = mk(OP_NX1,  CF_NB0,  1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd3:    w = mk(OP_NY0,  CF_NNA1, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd4:    w = mk(OP_NY1,  CF_NNA2, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd5:    w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd6:    w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_NONE, ACT_NOTCH, JMP_NEXT);
      5'd7:    w = mk(OP_VBX3, CF_BB0,  1'b1, ACC_NONE, ACT_NONE,  JMP_NEXT);
      5'd8:    w = mk(OP_BX1,  CF_BB2,  1'b1, ACC_LOAD, ACT_NONE,  JMP_NEXT);
      5'd9:    w = mk(OP_BY0,  CF_NBA1, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd10:   w = mk(OP_BY1,  CF_NBA2, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd11:   w = mk(OP_BY2,  CF_NBA3, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd12:   w = mk(OP_BY3,  CF_NBA4, 1'b1, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd13:   w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_ADD,  ACT_NONE,  JMP_NEXT);
      5'd14:   w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_NONE, ACT_BAND,  JMP_NEXT);
      5'd15:   w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_NONE, ACT_EMIT,  JMP_CHAN);
      5'd16:   w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_NONE, ACT_NONE,  JMP_OUT);
      default: w = mk(OP_ZERO, CF_NB0,  1'b0, ACC_NONE, ACT_NONE,  JMP_OUT);
    endcase
    return w;
  endfunction

endpackage

@@ sv/notch_bandpass_iir_8ch_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notch_bandpass_iir_8ch_top: eight-channel 50 Hz notch and 10-150 Hz bandpass.
// Per channel a second-order notch feeds a fourth-order bandpass, both direct
// form I, computed by one microcoded multiply-accumulate datapath.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Word
//   in       input      in_valid / in_ready   in_data   (in_word_t)
//   out      output     out_valid / out_ready out_data  (out_word_t)
//
// Words are taken one at a time: the next word is accepted only once the
// program has run through every channel, as the single shared multiplier
// and accumulator are stepped through eleven products per channel.
// Reset clears all filter histories at once; the block is ready right after.
// A finished word waits in the output register while the next word is taken;
// the program holds at its last step only while that register is still full.
module notch_bandpass_iir_8ch_top
  import nbi_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ucode_t          uc;
  logic [CH_W-1:0] ch;
  seq_stat_t       stat;
  out_word_t       res;
  logic            start;
  logic            out_free;
  logic            out_valid_r;
  out_word_t       out_r;

  assign in_ready  = !stat.busy;
  assign start     = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  nbi_sequencer #(.CHANNELS(CHANNELS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .uc       (uc),
    .ch       (ch),
    .stat     (stat)
  );

  nbi_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_load (start),
    .in_data (in_data),
    .uc      (uc),
    .ch      (ch),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (stat.out_load) begin
      out_r <= res;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_load |-> out_free)
    else $error("result loaded over a word still waiting");

endmodule

@@ sv/nbi_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbi_sequencer: microcode step counter and channel loop.
// Reads the program table, steps through it once per channel and hands the
// finished word to the output register when that register is free.
// ----------------------------------------------------------------------------
module nbi_sequencer
  import nbi_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_free,
  output ucode_t          uc,
  output logic [CH_W-1:0] ch,
  output seq_stat_t       stat
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            out_load;
  ucode_t          word;

  assign word = ucode_rom(pc_r);
  assign uc   = busy_r ? word : UC_NOP;
  assign ch   = ch_r;
  assign stat = '{busy: busy_r, out_load: out_load};

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    ch_nxt   = ch_r;
    out_load = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
        ch_nxt   = '0;
      end
    end else begin
      case (word.jmp)
        JMP_NEXT: pc_nxt = pc_r + PC_W'(1);
        JMP_CHAN: begin
          if (ch_r == CH_W'(CHANNELS - 1)) begin
            pc_nxt = pc_r + PC_W'(1);
          end else begin
            ch_nxt = ch_r + CH_W'(1);
            pc_nxt = word.target;
          end
        end
        JMP_OUT: begin
          if (out_free) begin
            out_load = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      ch_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      ch_r   <= ch_nxt;
    end
  end

  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (ch_r <= CH_W'(CHANNELS - 1)))
    else $error("channel index beyond the last channel");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= PC_W'(LAST_STEP)))
    else $error("step counter ran past the program");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (busy_r && pc_r == '0 && ch_r == '0))
    else $error("accepted word did not start the program at channel zero");

endmodule

@@ sv/nbi_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbi_datapath: shared multiply-accumulate unit and filter histories.
// One registered multiplier feeds an accumulator; control words select the
// operand, the coefficient and the history update for the current channel.
// ----------------------------------------------------------------------------
module nbi_datapath
  import nbi_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_load,
  input  in_word_t        in_data,
  input  ucode_t          uc,
  input  logic [CH_W-1:0] ch,
  output out_word_t       res
);

  logic signed [SAMPLE_W-1:0] in_samp [MAX_CH];
  logic signed [SAMPLE_W-1:0] samp_r  [CHANNELS];
  logic signed [SAMPLE_W-1:0] res_r   [CHANNELS];
  logic signed [SAMPLE_W-1:0] res_arr [MAX_CH];

  logic signed [SAMPLE_W-1:0] nx0_r [CHANNELS];
  logic signed [SAMPLE_W-1:0] nx1_r [CHANNELS];
  logic signed [HIST_W-1:0]   ny0_r [CHANNELS];
  logic signed [HIST_W-1:0]   ny1_r [CHANNELS];
  logic signed [HIST_W-1:0]   bx0_r [CHANNELS];
  logic signed [HIST_W-1:0]   bx1_r [CHANNELS];
  logic signed [HIST_W-1:0]   bx2_r [CHANNELS];
  logic signed [HIST_W-1:0]   bx3_r [CHANNELS];
  logic signed [HIST_W-1:0]   by0_r [CHANNELS];
  logic signed [HIST_W-1:0]   by1_r [CHANNELS];
  logic signed [HIST_W-1:0]   by2_r [CHANNELS];
  logic signed [HIST_W-1:0]   by3_r [CHANNELS];

  logic signed [HIST_W-1:0]  x_q8, nx0_q8, nx1_q8, acc_q8;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [COEF_W-1:0]  coef;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SAMPLE_W-1:0] out_s;

  // Round Q.28 to Q.8 (add half, floor shift) and saturate to the history width.
  function automatic logic signed [HIST_W-1:0] to_q8(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [HIST_W-1:0] r;
    s = (a + (ACC_W'(1) <<< 19)) >>> 20;
    if ((&s[ACC_W-1:HIST_W-1]) || !(|s[ACC_W-1:HIST_W-1])) begin
      r = s[HIST_W-1:0];
    end else begin
      r = s[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Round Q.8 to an integer sample and saturate to 16 bits.
  function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [HIST_W-1:0] w);
    logic signed [HIST_W:0] s;
    logic signed [SAMPLE_W-1:0] r;
    s = ((HIST_W+1)'(w) + (HIST_W+1)'(128)) >>> 8;
    if ((&s[HIST_W:SAMPLE_W-1]) || !(|s[HIST_W:SAMPLE_W-1])) begin
      r = s[SAMPLE_W-1:0];
    end else begin
      r = s[HIST_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_samp[0] = in_data.sample_ch0;
  assign in_samp[1] = in_data.sample_ch1;
  assign in_samp[2] = in_data.sample_ch2;
  assign in_samp[3] = in_data.sample_ch3;
  assign in_samp[4] = in_data.sample_ch4;
  assign in_samp[5] = in_data.sample_ch5;
  assign in_samp[6] = in_data.sample_ch6;
  assign in_samp[7] = in_data.sample_ch7;

  // Raw samples enter the notch scaled by 256.
  assign x_q8   = {samp_r[ch], 8'h00};
  assign nx0_q8 = {nx0_r[ch], 8'h00};
  assign nx1_q8 = {nx1_r[ch], 8'h00};
  assign coef   = coef_value(uc.coef);
  assign acc_q8 = to_q8(acc_r);
  assign out_s  = to_out(by0_r[ch]);

  always_comb begin
    case (uc.opnd)
      OP_ZERO: opnd = '0;
      OP_X:    opnd = OPND_W'(x_q8);
      OP_NX0:  opnd = OPND_W'(nx0_q8);
      OP_NX1:  opnd = OPND_W'(nx1_q8);
      OP_NY0:  opnd = OPND_W'(ny0_r[ch]);
      OP_NY1:  opnd = OPND_W'(ny1_r[ch]);
      OP_VBX3: opnd = OPND_W'(ny0_r[ch]) + OPND_W'(bx3_r[ch]);
      OP_BX1:  opnd = OPND_W'(bx1_r[ch]);
      OP_BY0:  opnd = OPND_W'(by0_r[ch]);
      OP_BY1:  opnd = OPND_W'(by1_r[ch]);
      OP_BY2:  opnd = OPND_W'(by2_r[ch]);
      OP_BY3:  opnd = OPND_W'(by3_r[ch]);
      default: opnd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        samp_r[i] <= in_samp[i];
      end
    end
    if (uc.mul_en) begin
      prod_r <= opnd * coef;
    end
    case (uc.acc)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      default:  acc_r <= acc_r;
    endcase
    if (uc.act == ACT_EMIT) begin
      res_r[ch] <= out_s;
    end
  end

  // Filter histories; the notch output lands in ny0 and is read back as the
  // bandpass input in the following steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        nx0_r[i] <= '0;
        nx1_r[i] <= '0;
        ny0_r[i] <= '0;
        ny1_r[i] <= '0;
        bx0_r[i] <= '0;
        bx1_r[i] <= '0;
        bx2_r[i] <= '0;
        bx3_r[i] <= '0;
        by0_r[i] <= '0;
        by1_r[i] <= '0;
        by2_r[i] <= '0;
        by3_r[i] <= '0;
      end
    end else begin
      case (uc.act)
        ACT_NOTCH: begin
          nx1_r[ch] <= nx0_r[ch];
          nx0_r[ch] <= samp_r[ch];
          ny1_r[ch] <= ny0_r[ch];
          ny0_r[ch] <= acc_q8;
        end
        ACT_BAND: begin
          bx3_r[ch] <= bx2_r[ch];
          bx2_r[ch] <= bx1_r[ch];
          bx1_r[ch] <= bx0_r[ch];
          bx0_r[ch] <= ny0_r[ch];
          by3_r[ch] <= by2_r[ch];
          by2_r[ch] <= by1_r[ch];
          by1_r[ch] <= by0_r[ch];
          by0_r[ch] <= acc_q8;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CH; i++) begin
      res_arr[i] = '0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      res_arr[i] = res_r[i];
    end
    res.filtered_ch0 = res_arr[0];
    res.filtered_ch1 = res_arr[1];
    res.filtered_ch2 = res_arr[2];
    res.filtered_ch3 = res_arr[3];
    res.filtered_ch4 = res_arr[4];
    res.filtered_ch5 = res_arr[5];
    res.filtered_ch6 = res_arr[6];
    res.filtered_ch7 = res_arr[7];
  end

  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.acc != ACC_NONE) |-> $past(uc.mul_en))
    else $error("accumulate without a product from the step before");

  a_emit_after_band: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.act == ACT_EMIT) |-> ($past(uc.act) == ACT_BAND))
    else $error("sample emitted before the bandpass history was updated");

endmodule
